>>> src/decision_graph_record_filter_unit_macros.svh
// Assertion macros shared by the decision-graph record filter modules.
// Depends on nothing; included by every module that carries assertions.
// Defining ASSERT_OFF removes all assertion bodies.
`ifndef DECISION_GRAPH_RECORD_FILTER_UNIT_MACROS_SVH
`define DECISION_GRAPH_RECORD_FILTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled at the rising clock edge.
`define DGRF_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, sampled at the rising clock edge.
`define DGRF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DGRF_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define DGRF_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

>>> src/dgrf_pkg.sv
// Shared types and constants of the decision-graph record filter.
// Depends on nothing; imported by the controller, datapath and top level.
package dgrf_pkg;

   // Store sizes. Both must be powers of two: indices are reduced by part-select.
   localparam int NODE_COUNT   = 1024;
   localparam int RECORD_WORDS = 64;
   localparam int LABEL_COUNT  = 16;

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int REC_W  = $clog2(RECORD_WORDS);
   localparam int STEP_W = $clog2(NODE_COUNT + 1);

   // Fixed field widths of the request and response payloads.
   localparam int ACTION_W    = 2;
   localparam int NODE_FIELD_W = 10;
   localparam int OFFSET_W    = 6;
   localparam int WORD_W      = 64;
   localparam int MODE_W      = 3;
   localparam int LABEL_W     = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE_NODE   = 2'd0,
      ACT_WRITE_RECORD = 2'd1,
      ACT_RUN          = 2'd2
   } action_type;

   typedef enum logic [MODE_W-1:0] {
      CMP_EQ    = 3'd0,
      CMP_GT    = 3'd1,
      CMP_LT    = 3'd2,
      CMP_GE    = 3'd3,
      CMP_LE    = 3'd4,
      CMP_BITS  = 3'd5
   } cmp_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_NODE = 1'b0,
      CSR_EXTENDED   = 1'b1
   } csr_index_type;

   // Node control word, 34 bits, label in the top bits and offset at the bottom.
   typedef struct packed {
      logic [LABEL_W-1:0]      label;
      cmp_mode_type            mode;
      logic                    invert;
      logic [NODE_FIELD_W-1:0] next_false;
      logic [NODE_FIELD_W-1:0] next_true;
      logic [OFFSET_W-1:0]     offset;
   } node_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RECORD,
      ST_EVAL
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic node_wr;
      logic rec_wr;
      logic node_rd;
      logic rec_rd;
      logic eval;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic idx_zero;
      logic steps_full;
      logic out_free;
   } sts_type;

endpackage

>>> src/dgrf_datapath.sv
// Datapath of the decision-graph record filter: node and record memories,
// walk registers, compare unit and the response register. Uses dgrf_pkg.
`include "decision_graph_record_filter_unit_macros.svh"

module dgrf_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  dgrf_pkg::cmd_type               cmd,
   output dgrf_pkg::sts_type               sts,
   input  logic [dgrf_pkg::NODE_FIELD_W-1:0] start_node,
   input  logic                            extended_enable,
   input  logic [dgrf_pkg::NODE_FIELD_W-1:0] req_node_index,
   input  logic [dgrf_pkg::OFFSET_W-1:0]   req_word_offset,
   input  logic [dgrf_pkg::WORD_W-1:0]     req_test_mask,
   input  logic [dgrf_pkg::WORD_W-1:0]     req_test_value,
   input  logic [dgrf_pkg::NODE_FIELD_W-1:0] req_next_if_true,
   input  logic [dgrf_pkg::NODE_FIELD_W-1:0] req_next_if_false,
   input  logic                            req_invert_flag,
   input  logic [dgrf_pkg::MODE_W-1:0]     req_compare_mode,
   input  logic [dgrf_pkg::LABEL_W-1:0]    req_label_id,
   input  logic [dgrf_pkg::OFFSET_W-1:0]   req_record_index,
   input  logic [dgrf_pkg::WORD_W-1:0]     req_record_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_matched,
   output logic [dgrf_pkg::LABEL_W-1:0]    rsp_label_out,
   output logic                            rsp_step_overflow
);
   import dgrf_pkg::*;

   // Node and record memories; contents are undefined until written.
   logic [WORD_W-1:0]  node_mask_mem  [NODE_COUNT];
   logic [WORD_W-1:0]  node_value_mem [NODE_COUNT];
   node_ctl_type       node_ctl_mem   [NODE_COUNT];
   logic [WORD_W-1:0]  record_mem     [RECORD_WORDS];

   // Registered memory read data.
   logic [WORD_W-1:0]  mask_q_ff;
   logic [WORD_W-1:0]  value_q_ff;
   node_ctl_type       ctl_q_ff;
   logic [WORD_W-1:0]  word_q_ff;

   // Walk state.
   logic [NODE_W-1:0]  idx_ff,   idx_in;
   logic [STEP_W-1:0]  steps_ff;
   logic               eval_ff,  eval_in;
   logic               inv_ff;
   logic [LABEL_W-1:0] label_ff, label_in;

   // Response register.
   logic               rsp_valid_ff;
   logic               rsp_matched_ff;
   logic [LABEL_W-1:0] rsp_label_ff;
   logic               rsp_overflow_ff;

   node_ctl_type       wr_ctl;
   logic [WORD_W-1:0]  masked;
   logic               cmp_eq;
   logic               cmp_gt;

   // Control word assembled from the request fields for a node write.
   always_comb begin
      wr_ctl.label      = req_label_id;
      wr_ctl.mode       = cmp_mode_type'(req_compare_mode);
      wr_ctl.invert     = req_invert_flag;
      wr_ctl.next_false = req_next_if_false;
      wr_ctl.next_true  = req_next_if_true;
      wr_ctl.offset     = req_word_offset;
   end

   // Node memories: one write port from requests, one read port for the walk.
   always_ff @(posedge clock) begin
      if (cmd.node_wr) begin
         node_mask_mem[req_node_index[NODE_W-1:0]]  <= req_test_mask;
         node_value_mem[req_node_index[NODE_W-1:0]] <= req_test_value;
         node_ctl_mem[req_node_index[NODE_W-1:0]]   <= wr_ctl;
      end
      if (cmd.node_rd) begin
         mask_q_ff  <= node_mask_mem[idx_ff];
         value_q_ff <= node_value_mem[idx_ff];
         ctl_q_ff   <= node_ctl_mem[idx_ff];
      end
   end

   // Record memory, read at the offset of the node just fetched.
   always_ff @(posedge clock) begin
      if (cmd.rec_wr) begin
         record_mem[req_record_index[REC_W-1:0]] <= req_record_word;
      end
      if (cmd.rec_rd) begin
         word_q_ff <= record_mem[ctl_q_ff.offset[REC_W-1:0]];
      end
   end

   // Compare unit: masked record word against the node value.
   assign masked = word_q_ff & mask_q_ff;
   assign cmp_eq = (masked == value_q_ff);
   assign cmp_gt = (masked > value_q_ff);

   always_comb begin
      if (extended_enable) begin
         case (ctl_q_ff.mode)
            CMP_EQ:    eval_in = cmp_eq;
            CMP_GT:    eval_in = cmp_gt;
            CMP_LT:    eval_in = !cmp_gt && !cmp_eq;
            CMP_GE:    eval_in = cmp_gt || cmp_eq;
            CMP_LE:    eval_in = !cmp_gt;
            CMP_BITS:  eval_in = ctl_q_ff.invert ? (masked != '0) : cmp_eq;
            default:   eval_in = 1'b0;
         endcase
      end else begin
         eval_in = cmp_eq;
      end
   end

   // In extended mode, a true test takes a valid nonzero label; a false test clears the label.
   always_comb begin
      label_in = label_ff;
      if (extended_enable) begin
         if (!eval_in) begin
            label_in = '0;
         end else if (ctl_q_ff.label != '0 && 32'(ctl_q_ff.label) < LABEL_COUNT) begin
            label_in = ctl_q_ff.label;
         end
      end
      idx_in = eval_in ? ctl_q_ff.next_true[NODE_W-1:0] : ctl_q_ff.next_false[NODE_W-1:0];
   end

   // Walk registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff   <= start_node[NODE_W-1:0];
         steps_ff <= '0;
         eval_ff  <= 1'b0;
         inv_ff   <= 1'b0;
         label_ff <= '0;
      end else begin
         if (cmd.node_rd) begin
            steps_ff <= steps_ff + STEP_W'(1);
         end
         if (cmd.eval) begin
            idx_ff   <= idx_in;
            eval_ff  <= eval_in;
            inv_ff   <= ctl_q_ff.invert;
            label_ff <= label_in;
         end
      end
   end

   // Response register; the walk ends either at node zero or by overflow.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_overflow_ff <= (idx_ff != '0);
         rsp_matched_ff  <= (idx_ff == '0) && (eval_ff ^ inv_ff);
         rsp_label_ff    <= (idx_ff == '0) ? label_ff : '0;
      end
   end

   // Status back to the controller.
   always_comb begin
      sts.idx_zero   = (idx_ff == '0);
      sts.steps_full = (steps_ff == STEP_W'(NODE_COUNT));
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = rsp_matched_ff;
   assign rsp_label_out     = rsp_label_ff;
   assign rsp_step_overflow = rsp_overflow_ff;

   // A finished walk always presents a response in the next cycle.
   `DGRF_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid_ff)
   // An aborted walk never reports a match or a label.
   `DGRF_ASSERT_IMPLY(a_overflow_clean, clock, reset, rsp_valid_ff && rsp_overflow_ff, !rsp_matched_ff && rsp_label_ff == '0)

endmodule

>>> src/dgrf_ctrl.sv
// Controller of the decision-graph record filter: request handshake and the
// state machine that sequences the walk. Uses dgrf_pkg.
`include "decision_graph_record_filter_unit_macros.svh"

module dgrf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dgrf_pkg::action_type req_action,
   input  dgrf_pkg::sts_type    sts,
   output dgrf_pkg::cmd_type    cmd
);
   import dgrf_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (req_action)
                  ACT_WRITE_NODE:   cmd.node_wr = 1'b1;
                  ACT_WRITE_RECORD: cmd.rec_wr  = 1'b1;
                  ACT_RUN: begin
                     cmd.start = 1'b1;
                     state_in  = ST_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            // Stop at node zero or when the step budget is spent.
            if (sts.idx_zero || sts.steps_full) begin
               if (sts.out_free) begin
                  cmd.emit = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.node_rd = 1'b1;
               state_in    = ST_RECORD;
            end
         end
         ST_RECORD: begin
            cmd.rec_rd = 1'b1;
            state_in   = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_CHECK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // A node is fetched only while the walk is still live.
   `DGRF_ASSERT_IMPLY(a_fetch_live, clock, reset, cmd.node_rd, !sts.idx_zero && !sts.steps_full)
   // The compare step always follows the record read.
   `DGRF_ASSERT_IMPLY(a_eval_order, clock, reset, state_ff == ST_EVAL, $past(state_ff == ST_RECORD))

endmodule

>>> src/decision_graph_record_filter_unit.sv
// Top level of the decision-graph record filter: configuration registers,
// controller and datapath. Uses dgrf_pkg, dgrf_ctrl and dgrf_datapath.
//
// A request writes a graph node, writes one 64-bit record word, or runs the
// filter. Writes give no response. A run raises rsp_valid from a register
// once each visited node has had one node-memory read, one record-memory read
// at that node's offset, and one 64-bit mask-and-compare, all in turn, and a
// final check has found the end of the walk. The longest run is aborted after
// 1024 visits. The block works on one request at a time and takes the next
// one the cycle after a run finishes, while the response waits in its output
// register; a run that finishes while an earlier response is still stalled
// waits until that response is taken. Node and record memories hold
// undefined data until written. csr_ready is always high; configuration must
// be written only while no run is in progress; the block does not enforce this.

module decision_graph_record_filter_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dgrf_pkg::ACTION_W-1:0]     req_action,
   input  logic [dgrf_pkg::NODE_FIELD_W-1:0] req_node_index,
   input  logic [dgrf_pkg::OFFSET_W-1:0]     req_word_offset,
   input  logic [dgrf_pkg::WORD_W-1:0]       req_test_mask,
   input  logic [dgrf_pkg::WORD_W-1:0]       req_test_value,
   input  logic [dgrf_pkg::NODE_FIELD_W-1:0] req_next_if_true,
   input  logic [dgrf_pkg::NODE_FIELD_W-1:0] req_next_if_false,
   input  logic                              req_invert_flag,
   input  logic [dgrf_pkg::MODE_W-1:0]       req_compare_mode,
   input  logic [dgrf_pkg::LABEL_W-1:0]      req_label_id,
   input  logic [dgrf_pkg::OFFSET_W-1:0]     req_record_index,
   input  logic [dgrf_pkg::WORD_W-1:0]       req_record_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_matched,
   output logic [dgrf_pkg::LABEL_W-1:0]      rsp_label_out,
   output logic                              rsp_step_overflow,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dgrf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dgrf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dgrf_pkg::*;

   logic [NODE_FIELD_W-1:0] start_node_ff;
   logic                    extended_ff;
   cmd_type                 cmd;
   sts_type                 sts;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_node_ff <= '0;
         extended_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_START_NODE: start_node_ff <= csr_wdata[NODE_FIELD_W-1:0];
            CSR_EXTENDED:   extended_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Walk sequencer.
   dgrf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (action_type'(req_action)),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Memories, compare unit and response register.
   dgrf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .start_node        (start_node_ff),
      .extended_enable   (extended_ff),
      .req_node_index    (req_node_index),
      .req_word_offset   (req_word_offset),
      .req_test_mask     (req_test_mask),
      .req_test_value    (req_test_value),
      .req_next_if_true  (req_next_if_true),
      .req_next_if_false (req_next_if_false),
      .req_invert_flag   (req_invert_flag),
      .req_compare_mode  (req_compare_mode),
      .req_label_id      (req_label_id),
      .req_record_index  (req_record_index),
      .req_record_word   (req_record_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_matched       (rsp_matched),
      .rsp_label_out     (rsp_label_out),
      .rsp_step_overflow (rsp_step_overflow)
   );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for decision_graph_record_filter_unit: a directed table, then
// phases of random graph, record and run requests checked against a predictor of the walk.
// Depends on dgrf_pkg and the RTL of the filter unit.
module tb;
   import dgrf_pkg::*;

   // Codes the package leaves unnamed.
   localparam logic [ACTION_W-1:0] ACT_UNUSED      = 2'd3;
   localparam logic [MODE_W-1:0]   CMP_RESERVED_LO = 3'd6;
   localparam logic [MODE_W-1:0]   CMP_RESERVED_HI = 3'd7;

   localparam int CYCLE_LIMIT    = 20_000_000;
   localparam int CSR_SETTLE     = 8;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PHASES         = 8;
   localparam int PHASE_REQUESTS = 160;

   localparam logic [WORD_W-1:0] ONES = '1;

   typedef struct {
      logic [ACTION_W-1:0]     action;
      logic [NODE_FIELD_W-1:0] node_index;
      logic [OFFSET_W-1:0]     word_offset;
      logic [WORD_W-1:0]       test_mask;
      logic [WORD_W-1:0]       test_value;
      logic [NODE_FIELD_W-1:0] next_if_true;
      logic [NODE_FIELD_W-1:0] next_if_false;
      logic                    invert_flag;
      logic [MODE_W-1:0]       compare_mode;
      logic [LABEL_W-1:0]      label_id;
      logic [OFFSET_W-1:0]     record_index;
      logic [WORD_W-1:0]       record_word;
   } filter_req_type;

   typedef struct packed {
      logic               matched;
      logic [LABEL_W-1:0] label;
      logic               overflow;
   } filter_verdict_type;

   // Outcome of walking the graph: a verdict, or the first unwritten slot on the path.
   typedef struct {
      bit                 hole;
      bit                 hole_is_node;
      int                 hole_slot;
      filter_verdict_type verdict;
   } walk_outcome_type;

   typedef enum {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      filter_req_type           req;
      logic [CSR_INDEX_W-1:0]   csr_idx;
      logic [CSR_DATA_W-1:0]    csr_data;
      bit                       typed;
      filter_verdict_type       verdict;
   } directed_row_type;

   // Block ports.
   logic                    clock;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_stall;
   logic [ACTION_W-1:0]     req_action        = '0;
   logic [NODE_FIELD_W-1:0] req_node_index    = '0;
   logic [OFFSET_W-1:0]     req_word_offset   = '0;
   logic [WORD_W-1:0]       req_test_mask     = '0;
   logic [WORD_W-1:0]       req_test_value    = '0;
   logic [NODE_FIELD_W-1:0] req_next_if_true  = '0;
   logic [NODE_FIELD_W-1:0] req_next_if_false = '0;
   logic                    req_invert_flag   = 1'b0;
   logic [MODE_W-1:0]       req_compare_mode  = '0;
   logic [LABEL_W-1:0]      req_label_id      = '0;
   logic [OFFSET_W-1:0]     req_record_index  = '0;
   logic [WORD_W-1:0]       req_record_word   = '0;
   logic                    rsp_valid;
   logic                    rsp_stall         = 1'b0;
   logic                    rsp_matched;
   logic [LABEL_W-1:0]      rsp_label_out;
   logic                    rsp_step_overflow;
   logic                    csr_valid         = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index         = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata         = '0;

   // Shadow copy of the filter graph, the record and the registers.
   logic [WORD_W-1:0]  node_mask_m  [NODE_COUNT];
   logic [WORD_W-1:0]  node_value_m [NODE_COUNT];
   node_ctl_type       node_ctl_m   [NODE_COUNT];
   bit                 node_known   [NODE_COUNT];
   logic [WORD_W-1:0]  record_m     [RECORD_WORDS];
   bit                 record_known [RECORD_WORDS];
   logic [NODE_W-1:0]  start_cfg    = '0;
   logic               extended_cfg = 1'b0;

   filter_verdict_type expected_verdicts[$];
   int              failures    = 0;
   int unsigned     cycle_count = 0;
   bit              calm        = 1'b0;
   int              stall_left  = 0;

   decision_graph_record_filter_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_node_index    (req_node_index),
      .req_word_offset   (req_word_offset),
      .req_test_mask     (req_test_mask),
      .req_test_value    (req_test_value),
      .req_next_if_true  (req_next_if_true),
      .req_next_if_false (req_next_if_false),
      .req_invert_flag   (req_invert_flag),
      .req_compare_mode  (req_compare_mode),
      .req_label_id      (req_label_id),
      .req_record_index  (req_record_index),
      .req_record_word   (req_record_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_matched       (rsp_matched),
      .rsp_label_out     (rsp_label_out),
      .rsp_step_overflow (rsp_step_overflow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Walk the shadow graph from the start node the way the block does.
   function automatic walk_outcome_type walk_graph();
      walk_outcome_type   w;
      logic [NODE_W-1:0]  idx;
      int                 steps;
      logic               taken;
      logic               inv;
      logic [LABEL_W-1:0] label;
      node_ctl_type       c;
      logic [WORD_W-1:0]  masked;
      logic [WORD_W-1:0]  v;
      w.hole = 0;
      w.hole_is_node = 0;
      w.hole_slot = 0;
      w.verdict = '0;
      idx = start_cfg;
      steps = 0;
      taken = 1'b0;
      inv = 1'b0;
      label = '0;
      while (idx != 0) begin
         if (steps == NODE_COUNT) begin
            w.verdict.overflow = 1'b1;
            return w;
         end
         if (!node_known[idx]) begin
            w.hole = 1;
            w.hole_is_node = 1;
            w.hole_slot = idx;
            return w;
         end
         c = node_ctl_m[idx];
         if (!record_known[c.offset]) begin
            w.hole = 1;
            w.hole_slot = c.offset;
            return w;
         end
         steps++;
         inv = c.invert;
         v = node_value_m[idx];
         masked = record_m[c.offset] & node_mask_m[idx];
         if (extended_cfg) begin
            case (c.mode)
               CMP_EQ:    taken = masked == v;
               CMP_GT:    taken = masked > v;
               CMP_LT:    taken = masked < v;
               CMP_GE:    taken = masked >= v;
               CMP_LE:    taken = masked <= v;
               CMP_BITS:  taken = inv ? (masked != 0) : (masked == v);
               default:   taken = 1'b0;
            endcase
            // A false test drops the label; a true labelled test takes its label.
            if (!taken)
               label = '0;
            else if (c.label != 0 && c.label < LABEL_COUNT)
               label = c.label;
         end else begin
            taken = masked == v;
         end
         idx = taken ? c.next_true : c.next_false;
      end
      w.verdict.matched = taken ^ inv;
      w.verdict.label = label;
      return w;
   endfunction

   // Successors mostly point a little forward, so most walks end; a few jump anywhere.
   function automatic logic [NODE_FIELD_W-1:0] pick_successor(int slot);
      int roll;
      int nxt;
      roll = $urandom_range(0, 99);
      if (roll < 25)
         return '0;
      if (roll < 92) begin
         nxt = slot + $urandom_range(1, 6);
         return (nxt > NODE_COUNT - 1) ? '0 : NODE_FIELD_W'(nxt);
      end
      return NODE_FIELD_W'($urandom_range(0, NODE_COUNT - 1));
   endfunction

   // Random node write, with mask and value shaped so that tests go both ways.
   function automatic filter_req_type make_node(int slot);
      filter_req_type    rq;
      logic [WORD_W-1:0] base;
      int                roll;
      rq.action        = ACT_WRITE_NODE;
      rq.node_index    = NODE_FIELD_W'(slot);
      rq.word_offset   = OFFSET_W'($urandom_range(0, RECORD_WORDS - 1));
      roll = $urandom_range(0, 9);
      if (roll < 3)
         rq.test_mask = ONES;
      else if (roll < 6)
         rq.test_mask = 64'hFF << (8 * $urandom_range(0, 7));
      else if (roll < 9)
         rq.test_mask = {$urandom, $urandom};
      else
         rq.test_mask = '0;
      rq.test_value = {$urandom, $urandom};
      if (record_known[rq.word_offset]) begin
         base = record_m[rq.word_offset] & rq.test_mask;
         case ($urandom_range(0, 4))
            0, 1:    rq.test_value = base;
            2:       rq.test_value = base + 1;
            3:       rq.test_value = base - 1;
            default: ;
         endcase
      end
      rq.next_if_true  = pick_successor(slot);
      rq.next_if_false = pick_successor(slot);
      rq.invert_flag   = 1'($urandom_range(0, 1));
      rq.compare_mode  = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(6, 7))
                                                     : MODE_W'($urandom_range(0, 5));
      rq.label_id      = LABEL_W'($urandom_range(0, 15));
      rq.record_index  = OFFSET_W'($urandom);
      rq.record_word   = {$urandom, $urandom};
      return rq;
   endfunction

   function automatic filter_req_type make_record(int idx);
      filter_req_type rq;
      rq = make_node($urandom_range(0, NODE_COUNT - 1));
      rq.action = ACT_WRITE_RECORD;
      rq.record_index = OFFSET_W'(idx);
      case ($urandom_range(0, 3))
         0, 1:    rq.record_word = {$urandom, $urandom};
         2:       rq.record_word = WORD_W'($urandom_range(0, 255));
         default: rq.record_word = $urandom_range(0, 1) ? ONES : '0;
      endcase
      return rq;
   endfunction

   // Idle lengths: mostly short, now and then long.
   function automatic int idle_length();
      return ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   function automatic int sender_gap();
      if (calm || $urandom_range(0, 99) < 60)
         return 0;
      return idle_length();
   endfunction

   function automatic directed_row_type node_row(
      logic [NODE_FIELD_W-1:0] slot, logic [OFFSET_W-1:0] off,
      logic [WORD_W-1:0] mask, logic [WORD_W-1:0] value,
      logic [NODE_FIELD_W-1:0] nt, logic [NODE_FIELD_W-1:0] nf,
      logic inv, logic [MODE_W-1:0] mode, logic [LABEL_W-1:0] label);
      directed_row_type r;
      r.kind = ROW_REQUEST;
      r.req = '{ACT_WRITE_NODE, slot, off, mask, value, nt, nf, inv, mode, label, '0, '0};
      r.csr_idx = '0;
      r.csr_data = '0;
      r.typed = 0;
      r.verdict = '0;
      return r;
   endfunction

   function automatic directed_row_type record_row(logic [OFFSET_W-1:0] idx,
                                                   logic [WORD_W-1:0] word);
      directed_row_type r;
      r = node_row('0, '0, '0, '0, '0, '0, 1'b0, CMP_EQ, '0);
      r.req.action = ACT_WRITE_RECORD;
      r.req.record_index = idx;
      r.req.record_word = word;
      return r;
   endfunction

   function automatic directed_row_type run_row(bit typed, filter_verdict_type verdict);
      directed_row_type r;
      r = node_row('0, '0, '0, '0, '0, '0, 1'b0, CMP_EQ, '0);
      r.req.action = ACT_RUN;
      r.typed = typed;
      r.verdict = verdict;
      return r;
   endfunction

   function automatic directed_row_type csr_row(logic [CSR_INDEX_W-1:0] idx,
                                                logic [CSR_DATA_W-1:0] data);
      directed_row_type r;
      r = node_row('0, '0, '0, '0, '0, '0, 1'b0, CMP_EQ, '0);
      r.kind = ROW_CSR;
      r.csr_idx = idx;
      r.csr_data = data;
      return r;
   endfunction

   // Present one request after a gap, hold it until accepted, then update the shadow state.
   task automatic send_request(filter_req_type rq, int gap, bit typed,
                               filter_verdict_type verdict);
      walk_outcome_type w;
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         = 1'b1;
      req_action        = rq.action;
      req_node_index    = rq.node_index;
      req_word_offset   = rq.word_offset;
      req_test_mask     = rq.test_mask;
      req_test_value    = rq.test_value;
      req_next_if_true  = rq.next_if_true;
      req_next_if_false = rq.next_if_false;
      req_invert_flag   = rq.invert_flag;
      req_compare_mode  = rq.compare_mode;
      req_label_id      = rq.label_id;
      req_record_index  = rq.record_index;
      req_record_word   = rq.record_word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (rq.action)
         ACT_WRITE_NODE: begin
            node_mask_m[rq.node_index]  = rq.test_mask;
            node_value_m[rq.node_index] = rq.test_value;
            node_ctl_m[rq.node_index]   = {rq.label_id, rq.compare_mode, rq.invert_flag,
                                           rq.next_if_false, rq.next_if_true, rq.word_offset};
            node_known[rq.node_index]   = 1;
         end
         ACT_WRITE_RECORD: begin
            record_m[rq.record_index]     = rq.record_word;
            record_known[rq.record_index] = 1;
         end
         ACT_RUN: begin
            w = walk_graph();
            expected_verdicts.push_back(typed ? verdict : w.verdict);
         end
         default: ;
      endcase
   endtask

   // Register writes happen only once the block has drained.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_START_NODE)
         start_cfg = data[NODE_W-1:0];
      else
         extended_cfg = data[0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Response back-pressure.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
         rsp_stall  <= 1'b1;
         stall_left <= idle_length() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare every accepted response with the oldest expected verdict.
   always @(posedge clock) begin
      filter_verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected response: matched %0d label %0d overflow %0d",
                   rsp_matched, rsp_label_out, rsp_step_overflow);
            failures++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_matched !== want.matched) begin
               $error("matched: expected %0d, actual %0d", want.matched, rsp_matched);
               failures++;
            end
            if (rsp_label_out !== want.label) begin
               $error("label_out: expected %0d, actual %0d", want.label, rsp_label_out);
               failures++;
            end
            if (rsp_step_overflow !== want.overflow) begin
               $error("step_overflow: expected %0d, actual %0d", want.overflow,
                      rsp_step_overflow);
               failures++;
            end
         end
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      directed_row_type  rows[$];
      directed_row_type  r;
      filter_req_type    rq;
      walk_outcome_type  w;
      int                roll;
      logic [NODE_W-1:0] start_pick;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table.
      rows.push_back(run_row(1, filter_verdict_type'{1'b0, 4'd0, 1'b0}));   // empty filter
      r = node_row('1, '1, ONES, ONES, '1, '1, 1'b1, CMP_RESERVED_HI, '1);
      r.req.action = ACT_UNUSED;
      r.req.record_index = '1;
      r.req.record_word = ONES;
      rows.push_back(r);
      rows.push_back(record_row(0, '0));
      rows.push_back(record_row(63, ONES));
      rows.push_back(record_row(5, 64'hF0));
      rows.push_back(node_row(0, 63, ONES, ONES, '1, '1, 1'b1, CMP_RESERVED_HI, '1));
      rows.push_back(node_row(1, 0, ONES, '0, 2, 0, 1'b0, CMP_EQ, 3));
      rows.push_back(node_row(2, 63, ONES, ONES, 0, 0, 1'b0, CMP_GT, 15));
      rows.push_back(csr_row(CSR_START_NODE, 1));
      rows.push_back(csr_row(CSR_EXTENDED, 0));
      rows.push_back(run_row(1, filter_verdict_type'{1'b1, 4'd0, 1'b0}));   // equality only
      rows.push_back(csr_row(CSR_EXTENDED, 1));
      rows.push_back(run_row(0, '0));
      // A chain through every compare mode but equality, ending on an undefined mode.
      rows.push_back(node_row(3, 5, 64'hFF, 64'h10, 4, 0, 1'b0, CMP_GT, 7));
      rows.push_back(node_row(4, 5, 64'hFF, 64'hF1, 6, 0, 1'b0, CMP_LT, 0));
      rows.push_back(node_row(6, 5, 64'hFF, 64'hF0, 7, 0, 1'b0, CMP_GE, 0));
      rows.push_back(node_row(7, 5, 64'hFF, 64'hF0, 8, 0, 1'b0, CMP_LE, 0));
      rows.push_back(node_row(8, 5, 64'h10, 64'h0, 9, 0, 1'b1, CMP_BITS, 0));
      rows.push_back(node_row(9, 5, 64'hF0, 64'hF0, 10, 0, 1'b0, CMP_BITS, 12));
      rows.push_back(node_row(10, 5, 64'hF0, 64'hF0, 0, 0, 1'b1, CMP_RESERVED_LO, 0));
      rows.push_back(csr_row(CSR_START_NODE, 3));
      rows.push_back(run_row(0, '0));
      // A node that loops onto itself forces the step limit.
      rows.push_back(node_row('1, 0, ONES, '0, '1, '1, 1'b0, CMP_EQ, 0));
      rows.push_back(csr_row(CSR_START_NODE, '1));
      rows.push_back(run_row(1, filter_verdict_type'{1'b0, 4'd0, 1'b1}));

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR)
            write_csr(rows[i].csr_idx, rows[i].csr_data);
         else
            send_request(rows[i].req, sender_gap(), rows[i].typed, rows[i].verdict);
      end

      // Random phases, each with its own register setting.
      for (int phase = 0; phase < PHASES; phase++) begin
         calm = (phase == 0 || phase == 4);
         if (phase == 2)
            start_pick = '0;
         else if (phase == 5)
            start_pick = NODE_W'($urandom_range(1, NODE_COUNT - 1));
         else
            start_pick = NODE_W'($urandom_range(1, 20));
         write_csr(CSR_START_NODE, start_pick);
         write_csr(CSR_EXTENDED, {(CSR_DATA_W - 1)'($urandom), 1'(phase & 1)});
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               rq = make_node($urandom_range(0, NODE_COUNT - 1));
               rq.action = ACT_UNUSED;
            end else if (roll < 40) begin
               // A run whose path still touches unwritten slots is replaced by a write to the first of them.
               rq = make_node($urandom_range(0, NODE_COUNT - 1));
               rq.action = ACT_RUN;
               w = walk_graph();
               if (w.hole)
                  rq = w.hole_is_node ? make_node(w.hole_slot) : make_record(w.hole_slot);
            end else if (roll < 72) begin
               rq = make_node(($urandom_range(0, 99) < 75) ? $urandom_range(1, 24)
                                                          : $urandom_range(0, NODE_COUNT - 1));
            end else begin
               rq = make_record($urandom_range(0, RECORD_WORDS - 1));
            end
            // Now and then hold off until every pending run has answered.
            if (!calm && $urandom_range(0, 99) < 2) begin
               @(negedge clock);
               req_valid = 1'b0;
               while (expected_verdicts.size() != 0) @(posedge clock);
            end
            send_request(rq, sender_gap(), 0, '0);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/dgrf_pkg.sv
src/dgrf_datapath.sv
src/dgrf_ctrl.sv
src/decision_graph_record_filter_unit.sv
tb/sv/tb.sv
